### design/tphc_pkg.sv
// ----------------------------------------------------------------------------
// tphc_pkg
// Shared types and constants of the tournament Hamiltonian path counter.
// ----------------------------------------------------------------------------
package tphc_pkg;

  localparam int VC_W     = 4;
  localparam int ARC_W    = 28;
  localparam int COUNT_W  = 16;
  localparam int SPREAD_W = 8;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic            REG_VERTEX_COUNT = 1'b0;
  localparam logic [VC_W-1:0] VC_RESET         = 4'd8;

  typedef struct packed {
    logic            start;
    logic [VC_W-1:0] n;
  } job_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_TOURN,
    TOP_COUNT,
    TOP_DELIVER
  } top_state_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_PAIRS,
    TS_SCORE,
    TS_DONE
  } tourn_state_t;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_READ,
    DS_WRITE,
    DS_DONE
  } dp_state_t;

  function automatic int tphc_fact(input int k);
    int f;
    f = 1;
    for (int i = 2; i <= k; i++) begin
      f = f * i;
    end
    return f;
  endfunction

endpackage

### design/tphc_regs.sv
// ----------------------------------------------------------------------------
// tphc_regs
// Configuration register file on the APB-style port.
// ----------------------------------------------------------------------------
module tphc_regs import tphc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [VC_W-1:0]    vertex_count
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (wr_en && (paddr[2] == REG_VERTEX_COUNT)) begin
      vertex_count <= pwdata[VC_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_VERTEX_COUNT: prdata = PDATA_W'(vertex_count);
      default:          prdata = '0;
    endcase
  end

endmodule

### design/tphc_tourn.sv
// ----------------------------------------------------------------------------
// tphc_tourn
// Builds the adjacency rows one vertex pair per cycle, then sums the squared
// score deviations one vertex per cycle.
// ----------------------------------------------------------------------------
module tphc_tourn import tphc_pkg::*; #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  job_t                                     job,
  input  logic [ARC_W-1:0]                         arc_bits,
  output logic [MAX_VERTICES-1:0][MAX_VERTICES-1:0] adj,
  output logic [SPREAD_W-1:0]                      score,
  output logic                                     done
);

  localparam int IW = $clog2(MAX_VERTICES);

  tourn_state_t      state, state_next;
  logic [VC_W-1:0]   n_q;
  logic [VC_W-1:0]   nm1;
  logic [IW-1:0]     i, j, k;
  logic [ARC_W-1:0]  sr;
  logic              i_last, j_last, k_last;
  logic [VC_W-1:0]   pop;
  logic [VC_W:0]     two_s, nm1x, dev;
  logic [9:0]        sq;
  logic [10:0]       sum;
  logic [SPREAD_W-1:0] score_next;

  assign nm1    = n_q - 1'b1;
  assign i_last = (VC_W'(i) == nm1 - 1'b1);
  assign j_last = (VC_W'(j) == nm1);
  assign k_last = (VC_W'(k) == nm1);

  always_comb begin
    pop = '0;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      pop = pop + VC_W'(adj[k][v]);
    end
    two_s      = {pop, 1'b0};
    nm1x       = {1'b0, nm1};
    dev        = (two_s >= nm1x) ? (two_s - nm1x) : (nm1x - two_s);
    sq         = 10'(dev) * 10'(dev);
    sum        = 11'(score) + 11'(sq);
    score_next = (sum > 11'd255) ? '1 : sum[SPREAD_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      TS_IDLE: begin
        if (job.start) begin
          state_next = (job.n == VC_W'(1)) ? TS_SCORE : TS_PAIRS;
        end
      end
      TS_PAIRS: begin
        if (i_last && j_last) state_next = TS_SCORE;
      end
      TS_SCORE: begin
        if (k_last) state_next = TS_DONE;
      end
      TS_DONE:  state_next = TS_IDLE;
      default:  state_next = TS_IDLE;
    endcase
  end

  always_comb begin
    done = (state == TS_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job.start && (state == TS_IDLE)) begin
      n_q   <= job.n;
      sr    <= arc_bits;
      i     <= '0;
      j     <= IW'(1);
      k     <= '0;
      score <= '0;
      adj   <= '0;
    end else if (state == TS_PAIRS) begin
      if (sr[0]) begin
        adj[i][j] <= 1'b1;
      end else begin
        adj[j][i] <= 1'b1;
      end
      sr <= sr >> 1;
      if (j_last) begin
        i <= i + 1'b1;
        j <= i + IW'(2);
      end else begin
        j <= j + 1'b1;
      end
    end else if (state == TS_SCORE) begin
      score <= score_next;
      k     <= k + 1'b1;
    end
  end

endmodule

### design/tphc_dp.sv
// ----------------------------------------------------------------------------
// tphc_dp
// Subset dynamic program over a table memory with one row per vertex subset.
// Each row entry is rebuilt from one earlier row read per end vertex.
// ----------------------------------------------------------------------------
module tphc_dp import tphc_pkg::*; #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  job_t                                     job,
  input  logic [MAX_VERTICES-1:0][MAX_VERTICES-1:0] adj,
  output logic [COUNT_W-1:0]                       path_count,
  output logic                                     done
);

  localparam int CW    = $clog2(tphc_fact(MAX_VERTICES) + 1);
  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int DEPTH = 1 << MAX_VERTICES;
  localparam int TW    = (CW > COUNT_W) ? CW : COUNT_W;

  typedef logic [MAX_VERTICES-1:0][CW-1:0] row_t;

  row_t mem [DEPTH];

  dp_state_t               state, state_next;
  logic [VC_W-1:0]         n_q;
  logic [VC_W-1:0]         nm1;
  logic [MAX_VERTICES-1:0] mask, full, raddr;
  logic [IW-1:0]           w;
  logic                    w_last;
  logic                    issue, mem_we;
  logic                    rd_vld, rd_inmask, rd_single;
  logic [IW-1:0]           rd_w;
  logic [MAX_VERTICES-1:0] rd_sub;
  row_t                    rdata, row, row_next;
  logic [CW-1:0]           entry, tot;
  logic [TW-1:0]           tot_x;

  assign nm1    = n_q - 1'b1;
  assign full   = ~({MAX_VERTICES{1'b1}} << n_q);
  assign w_last = (VC_W'(w) == nm1);
  assign raddr  = mask ^ (MAX_VERTICES'(1) << w);

  always_comb begin
    entry = '0;
    if (rd_inmask) begin
      if (rd_single) begin
        entry = CW'(1);
      end else begin
        for (int v = 0; v < MAX_VERTICES; v++) begin
          if (rd_sub[v] && adj[v][rd_w]) entry = entry + rdata[v];
        end
      end
    end
  end

  always_comb begin
    row_next = row;
    if (rd_vld) row_next[rd_w] = entry;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DS_IDLE:  if (job.start) state_next = DS_READ;
      DS_READ:  if (w_last) state_next = DS_WRITE;
      DS_WRITE: state_next = (mask == full) ? DS_DONE : DS_READ;
      DS_DONE:  state_next = DS_IDLE;
      default:  state_next = DS_IDLE;
    endcase
  end

  always_comb begin
    issue  = (state == DS_READ);
    mem_we = (state == DS_WRITE);
    done   = (state == DS_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= DS_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (job.start && (state == DS_IDLE)) begin
      n_q  <= job.n;
      mask <= MAX_VERTICES'(1);
      w    <= '0;
      row  <= '0;
      tot  <= '0;
    end else begin
      if (issue) w <= w_last ? '0 : w + 1'b1;
      if (mem_we) mask <= mask + 1'b1;
      row <= row_next;
      if (rd_vld && (mask == full)) tot <= tot + entry;
    end
    rd_w      <= w;
    rd_sub    <= raddr;
    rd_inmask <= mask[w];
    rd_single <= (raddr == '0);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mask] <= row_next;
    rdata <= mem[raddr];
  end

  assign tot_x      = TW'(tot);
  assign path_count = (tot_x > TW'({COUNT_W{1'b1}})) ? '1 : tot_x[COUNT_W-1:0];

endmodule

### design/tournament_hamiltonian_path_counter.sv
// ----------------------------------------------------------------------------
// tournament_hamiltonian_path_counter
// Each request carries a tournament as one orientation bit per vertex pair;
// the block returns its Hamiltonian path count (saturating at 65535) and its
// score spread. One request is processed at a time. With n active vertices a
// request first builds the adjacency rows from its n(n-1)/2 orientation bits,
// then computes the score spread and then the path count. The path count
// dominates: the table memory has one read port, and each subset row needs
// one read per end vertex and a write-back. The table needs no clearing pass,
// since every row whose data is used is written before it is read within a
// request. A finished result waits in an output register, and the next
// request is taken while it is still held.
// ----------------------------------------------------------------------------
module tournament_hamiltonian_path_counter import tphc_pkg::*; #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ARC_W-1:0]    arc_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  path_count,
  output logic [SPREAD_W-1:0] score_spread
);

  top_state_t                               state, state_next;
  logic [VC_W-1:0]                          vertex_count;
  logic [VC_W-1:0]                          n_clamp;
  logic                                     accept;
  logic                                     dp_start;
  logic                                     out_load;
  job_t                                     tourn_job, dp_job;
  logic [MAX_VERTICES-1:0][MAX_VERTICES-1:0] adj;
  logic [SPREAD_W-1:0]                      tourn_score;
  logic                                     tourn_done;
  logic [COUNT_W-1:0]                       dp_count;
  logic                                     dp_done;

  tphc_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .vertex_count (vertex_count)
  );

  always_comb begin
    if (vertex_count == '0) begin
      n_clamp = VC_W'(1);
    end else if (vertex_count > VC_W'(MAX_VERTICES)) begin
      n_clamp = VC_W'(MAX_VERTICES);
    end else begin
      n_clamp = vertex_count;
    end
  end

  assign accept    = in_valid && !in_stall;
  assign tourn_job = '{start: accept, n: n_clamp};
  assign dp_job    = '{start: dp_start, n: n_clamp};

  tphc_tourn #(.MAX_VERTICES(MAX_VERTICES)) u_tourn (
    .clk      (clk),
    .rst      (rst),
    .job      (tourn_job),
    .arc_bits (arc_bits),
    .adj      (adj),
    .score    (tourn_score),
    .done     (tourn_done)
  );

  tphc_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .job        (dp_job),
    .adj        (adj),
    .path_count (dp_count),
    .done       (dp_done)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      TOP_IDLE:    if (in_valid) state_next = TOP_TOURN;
      TOP_TOURN:   if (tourn_done) state_next = TOP_COUNT;
      TOP_COUNT:   if (dp_done) state_next = TOP_DELIVER;
      TOP_DELIVER: if (!out_valid || !out_stall) state_next = TOP_IDLE;
      default:     state_next = TOP_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != TOP_IDLE);
    dp_start = (state == TOP_TOURN) && tourn_done;
    out_load = (state == TOP_DELIVER) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= TOP_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      path_count   <= dp_count;
      score_spread <= tourn_score;
    end
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request accepted while another request is in progress");

  a_done_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(tourn_done && dp_done))
    else $error("adjacency builder and path counter finished together");

  a_dp_done_phase: assert property (@(posedge clk) disable iff (rst)
    dp_done |-> (state == TOP_COUNT))
    else $error("path counter finished outside the counting phase");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && out_stall))
    else $error("held result overwritten before it was taken");
`endif

endmodule

### tb/tournament_hamiltonian_path_counter_test.sv
// ----------------------------------------------------------------------------
// tournament_hamiltonian_path_counter_test
// Sends tournaments to the path counter at several vertex counts, including
// zero and values above the built maximum, with and without idle cycles on
// either side. A long receiver hold-off fills the block until it stalls new
// requests. Every result is checked against a path count and score spread
// computed here with a subset dynamic program.
// ----------------------------------------------------------------------------
module tournament_hamiltonian_path_counter_test import tphc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_V     = 8;
  localparam int IDLE_PCT  = 55;
  localparam int BOTH_PCT  = 8;
  localparam int SETTLE    = 3000;
  localparam int HOLD_OFF  = 400;

  typedef struct {
    logic [COUNT_W-1:0]  paths;
    logic [SPREAD_W-1:0] spread;
  } tally_t;

  class tally_board;
    int unsigned vertex_count;
    tally_t      pending_tallies[$];
    int          mismatches;

    function new();
      vertex_count = VC_RESET;
      mismatches = 0;
    endfunction

    function tally_t tournament_tally(logic [ARC_W-1:0] arc);
      int unsigned          n;
      int unsigned          p;
      int unsigned          full;
      int unsigned          total;
      int unsigned          sum;
      int                   ds;
      logic [MAX_V-1:0]     rows [MAX_V];
      int unsigned          ways [2**MAX_V][MAX_V];
      tally_t               t;
      n = vertex_count;
      if (n < 1) n = 1;
      if (n > MAX_V) n = MAX_V;
      foreach (rows[i]) rows[i] = '0;
      foreach (ways[m, v]) ways[m][v] = 0;
      p = 0;
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (p < ARC_W && arc[p]) rows[i][j] = 1'b1;
          else rows[j][i] = 1'b1;
          p++;
        end
      end
      full = (1 << n) - 1;
      for (int v = 0; v < n; v++) ways[1 << v][v] = 1;
      for (int unsigned mask = 1; mask <= full; mask++) begin
        for (int v = 0; v < n; v++) begin
          if (mask[v] && ways[mask][v] != 0) begin
            for (int w = 0; w < n; w++) begin
              if (!mask[w] && rows[v][w])
                ways[mask | (1 << w)][w] += ways[mask][v];
            end
          end
        end
      end
      total = 0;
      for (int v = 0; v < n; v++) total += ways[full][v];
      sum = 0;
      for (int i = 0; i < n; i++) begin
        ds = 2 * int'($countones(rows[i])) - (int'(n) - 1);
        sum += ds * ds;
      end
      t.paths = (total > 65535) ? 16'hFFFF : COUNT_W'(total);
      t.spread = (sum > 255) ? 8'hFF : SPREAD_W'(sum);
      return t;
    endfunction

    function void note_tournament(logic [ARC_W-1:0] arc);
      pending_tallies.push_back(tournament_tally(arc));
    endfunction

    function void check_tally(logic [COUNT_W-1:0] paths, logic [SPREAD_W-1:0] spread);
      tally_t want;
      if (pending_tallies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: paths %0d spread %0d", paths, spread);
        return;
      end
      want = pending_tallies.pop_front();
      if (paths !== want.paths || spread !== want.spread) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected paths %0d spread %0d, got paths %0d spread %0d",
                   want.paths, want.spread, paths, spread);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  logic [ARC_W-1:0]    arc_bits;
  logic                out_valid;
  logic                out_stall;
  logic [COUNT_W-1:0]  path_count;
  logic [SPREAD_W-1:0] score_spread;

  tally_board board;
  int         sender_idle_pct;
  int         receiver_stall_pct;
  int         hold_off_cycles;

  tournament_hamiltonian_path_counter #(.MAX_VERTICES(MAX_V)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .arc_bits(arc_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .path_count(path_count), .score_spread(score_spread)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_tournament(arc_bits);
      if (out_valid && !out_stall) board.check_tally(path_count, score_spread);
    end
  end

  // The receiver counts out a requested hold-off before stalling at random again.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  task automatic write_vertex_count(input logic [VC_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * REG_VERTEX_COUNT);
    pwdata <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.vertex_count = value;
  endtask

  task automatic send_tournament(input logic [ARC_W-1:0] arc);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    arc_bits <= arc;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (board.pending_tallies.size() != 0 || hold_off_cycles != 0) @(negedge clk);
  endtask

  task automatic run_phase(input logic [VC_W-1:0] vc, input int requests,
                           input int idle_pct, input int stall_pct, input bit squeeze);
    wait_for_results();
    write_vertex_count(vc);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    if (squeeze) hold_off_cycles = HOLD_OFF;
    for (int k = 0; k < requests; k++) send_tournament(ARC_W'($urandom));
  endtask

  initial begin
    logic [ARC_W-1:0] directed [$];
    board = new();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    arc_bits = '0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed = '{28'h0000000, 28'hFFFFFFF, 28'hAAAAAAA, 28'h5555555,
                 28'h0000001, 28'h8000000, 28'h00000FE, 28'hF0F0F0F};
    foreach (directed[i]) send_tournament(directed[i]);

    run_phase(4'd3, 40, 0, 0, 1'b1);
    run_phase(4'd5, 40, IDLE_PCT, 0, 1'b0);
    run_phase(4'd0, 15, 0, IDLE_PCT, 1'b0);
    run_phase(4'd1, 15, BOTH_PCT, BOTH_PCT, 1'b0);
    run_phase(4'd2, 20, 0, 0, 1'b0);
    run_phase(4'd15, 20, 0, IDLE_PCT, 1'b0);
    run_phase(4'd6, 40, BOTH_PCT, BOTH_PCT, 1'b0);
    run_phase(4'd4, 40, IDLE_PCT, 0, 1'b0);
    run_phase(4'd7, 25, 0, IDLE_PCT, 1'b0);
    run_phase(4'd8, 15, 0, 0, 1'b0);
    run_phase(4'd13, 20, BOTH_PCT, BOTH_PCT, 1'b0);

    wait_for_results();
    repeat (SETTLE) @(negedge clk);
    if (board.mismatches == 0 && board.pending_tallies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
design/tphc_pkg.sv
design/tphc_regs.sv
design/tphc_tourn.sv
design/tphc_dp.sv
design/tournament_hamiltonian_path_counter.sv
tb/tournament_hamiltonian_path_counter_test.sv
